/* rtl/core/hmmbc_pkg.sv */
// Package with shared types and constants of the memory map bank controller.
package hmmbc_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_LROM  = 2'd2,
        FUNC_LBOOT = 2'd3
    } func_t;

    localparam logic [1:0] CFG_CTRL_TYPE = 2'd0;
    localparam logic [1:0] CFG_EXT_RAM   = 2'd1;
    localparam logic [1:0] CFG_BOOT      = 2'd2;

    localparam logic [1:0] CTRL_MBC1 = 2'd1;
    localparam logic [1:0] CTRL_MBC3 = 2'd2;

    localparam logic [1:0] XRAM_NONE = 2'd0;
    localparam logic [1:0] XRAM_2K   = 2'd1;
    localparam logic [1:0] XRAM_8K   = 2'd2;

    localparam logic [15:0] ADDR_DMA   = 16'hFF46;
    localparam logic [15:0] ADDR_UNMAP = 16'hFF50;
    localparam logic [7:0]  OAM_COPY_BYTES = 8'd160;

    // One queued item between the front and the back end.
    typedef struct packed {
        func_t       func;
        logic [15:0] addr;
        logic [18:0] load_index;
        logic [7:0]  data;
    } item_t;

endpackage

/* rtl/core/hmmbc_front.sv */
// Front end: accepts input beats into a two-entry queue for the back end.
module hmmbc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hmmbc_pkg::item_t   in_item,
    output logic               q_valid,
    input  logic               q_ready,
    output hmmbc_pkg::item_t   q_item
);
    hmmbc_pkg::item_t q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2)
        else $error("full queue lost an entry");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
endmodule

/* rtl/core/hmmbc_back.sv */
// Back end: memories, bank registers, OAM copy engine and result register.
module hmmbc_back #(
    parameter int ROM_BANKS      = 32,
    parameter int CART_RAM_BANKS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         controller_type,
    input  logic [1:0]         ext_ram_code,
    input  logic               boot_load,
    input  logic               boot_value,
    input  logic               q_valid,
    output logic               q_ready,
    input  hmmbc_pkg::item_t   q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_data
);
    localparam int RomAw  = $clog2(ROM_BANKS) + 14;
    localparam int RomBw  = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
    localparam int CramBw = (CART_RAM_BANKS > 1) ? $clog2(CART_RAM_BANKS) : 1;
    localparam int CramAw = CramBw + 13;
    // Reciprocal of the bank count, exact for every 7-bit bank number.
    localparam int RomRecip = (16384 + ROM_BANKS - 1) / ROM_BANKS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_DONE   = 6'b000100,
        ST_DMA_RD = 6'b001000,
        ST_DMA_WR = 6'b010000,
        ST_CLEAR  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        SRC_ZERO, SRC_BOOT, SRC_ROM, SRC_VRAM, SRC_CRAM, SRC_WRAM, SRC_HIGH
    } src_t;

    logic [7:0] boot_mem [256];
    logic [7:0] rom_mem  [ROM_BANKS*16384];
    logic [7:0] vram_mem [8192];
    logic [7:0] cram_mem [CART_RAM_BANKS*8192];
    logic [7:0] wram_mem [8192];
    logic [7:0] high_mem [512];

    state_t     state_reg;
    logic [6:0] rom_bank_reg;
    logic [1:0] ram_bank_reg;
    logic       mode_reg, boot_mapped_reg;
    logic [7:0] dma_src_reg, dma_cnt_reg;
    logic [8:0] clr_cnt_reg;
    src_t       src_reg;
    logic [6:0] rom_lo_wrap_reg, rom_hi_wrap_reg;
    logic [7:0] boot_q, rom_q, vram_q, cram_q, wram_q, high_q;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;

    logic [15:0]       raddr;
    src_t              rsrc;
    logic [RomAw-1:0]  rom_ra;
    logic [CramAw-1:0] cram_ia;
    logic [6:0]        hi_bank, lo_bank;
    logic [7:0]        rd_byte;
    logic [15:0]       dma_addr;

    // Bank number modulo the bank count by reciprocal multiplication.
    function automatic logic [6:0] rom_wrap(input logic [6:0] b);
        logic [21:0] prod;
        logic [6:0]  quo;
        logic [13:0] back_mul;
        prod     = 22'(b) * 22'(RomRecip);
        quo      = prod[20:14];
        back_mul = 14'(quo) * 14'(ROM_BANKS);
        return b - back_mul[6:0];
    endfunction

    // Bank math.
    always_comb begin
        logic [4:0] low5;
        logic [6:0] rb;
        logic [1:0] cb;
        logic [4:0] cw;
        low5 = (rom_bank_reg[4:0] == 5'd0) ? 5'd1 : rom_bank_reg[4:0];
        rb = (rom_bank_reg == 7'd0) ? 7'd1 : rom_bank_reg;
        if (controller_type == hmmbc_pkg::CTRL_MBC1) hi_bank = {ram_bank_reg, low5};
        else if (controller_type == hmmbc_pkg::CTRL_MBC3) hi_bank = rb;
        else hi_bank = 7'd1;
        lo_bank = (controller_type == hmmbc_pkg::CTRL_MBC1 && mode_reg) ?
                  {ram_bank_reg, 5'd0} : 7'd0;
        cb = 2'd0;
        if (controller_type == hmmbc_pkg::CTRL_MBC1) cb = mode_reg ? ram_bank_reg : 2'd0;
        else if (controller_type == hmmbc_pkg::CTRL_MBC3) cb = ram_bank_reg;
        // The RAM bank is at most three, so three compare and subtract steps wrap it.
        cw = {3'b000, cb};
        for (int k = 0; k < 3; k++) begin
            if (cw >= 5'(CART_RAM_BANKS))
                cw = cw - 5'(CART_RAM_BANKS);
        end
        if (ext_ram_code == hmmbc_pkg::XRAM_2K)
            cram_ia = CramAw'({2'b0, raddr[10:0]});
        else if (ext_ram_code == hmmbc_pkg::XRAM_8K)
            cram_ia = CramAw'(raddr[12:0]);
        else
            cram_ia = CramAw'({cw[CramBw-1:0], raddr[12:0]});
    end

    assign dma_addr = {dma_src_reg, dma_cnt_reg};
    assign raddr = (state_reg == ST_DMA_RD) ? dma_addr : q_item.addr;

    // ROM banks come from registers that follow the bank registers in the next
    // cycle; no read is taken until a bank write's result has been accepted.
    always_comb begin
        logic [6:0] bank;
        rsrc = SRC_HIGH;
        bank = rom_hi_wrap_reg;
        if (raddr < 16'h4000) begin
            rsrc = (raddr < 16'h0100 && boot_mapped_reg) ? SRC_BOOT : SRC_ROM;
            bank = rom_lo_wrap_reg;
        end else if (raddr < 16'h8000) rsrc = SRC_ROM;
        else if (raddr < 16'hA000) rsrc = SRC_VRAM;
        else if (raddr < 16'hC000)
            rsrc = (ext_ram_code == hmmbc_pkg::XRAM_NONE) ? SRC_ZERO : SRC_CRAM;
        else if (raddr < 16'hFE00) rsrc = SRC_WRAM;
        rom_ra = RomAw'({RomBw'(bank), raddr[13:0]});
    end

    always_comb begin
        case (src_reg)
            SRC_BOOT: rd_byte = boot_q;
            SRC_ROM:  rd_byte = rom_q;
            SRC_VRAM: rd_byte = vram_q;
            SRC_CRAM: rd_byte = cram_q;
            SRC_WRAM: rd_byte = wram_q;
            SRC_HIGH: rd_byte = high_q;
            default:  rd_byte = 8'd0;
        endcase
    end

    assign q_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    logic take, wr_en;
    assign take  = q_valid && q_ready;
    assign wr_en = take && q_item.func == hmmbc_pkg::FUNC_WRITE;

    // Memory ports, registered reads.
    always_ff @(posedge aclk) begin
        boot_q <= boot_mem[raddr[7:0]];
        rom_q  <= rom_mem[rom_ra];
        vram_q <= vram_mem[raddr[12:0]];
        cram_q <= cram_mem[cram_ia];
        wram_q <= wram_mem[raddr[12:0]];
        high_q <= high_mem[raddr[8:0]];
        src_reg <= rsrc;
        rom_lo_wrap_reg <= rom_wrap(lo_bank);
        rom_hi_wrap_reg <= rom_wrap(hi_bank);
        if (take && q_item.func == hmmbc_pkg::FUNC_LBOOT && q_item.load_index < 19'd256)
            boot_mem[q_item.load_index[7:0]] <= q_item.data;
        if (take && q_item.func == hmmbc_pkg::FUNC_LROM &&
            22'(q_item.load_index) < 22'(ROM_BANKS*16384))
            rom_mem[RomAw'(q_item.load_index)] <= q_item.data;
        if (wr_en && q_item.addr[15:13] == 3'b100)
            vram_mem[q_item.addr[12:0]] <= q_item.data;
        if (wr_en && q_item.addr[15:13] == 3'b101 && ext_ram_code != hmmbc_pkg::XRAM_NONE)
            cram_mem[cram_ia] <= q_item.data;
        if (wr_en && q_item.addr >= 16'hC000 && q_item.addr < 16'hFE00)
            wram_mem[q_item.addr[12:0]] <= q_item.data;
        if (wr_en && q_item.addr >= 16'hFE00)
            high_mem[q_item.addr[8:0]] <= q_item.data;
        else if (state_reg == ST_DMA_WR)
            high_mem[{1'b0, dma_cnt_reg}] <= rd_byte;
        else if (state_reg == ST_CLEAR)
            high_mem[clr_cnt_reg] <= 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            rom_bank_reg <= 7'd1;
            ram_bank_reg <= 2'd0;
            mode_reg <= 1'b0;
            boot_mapped_reg <= 1'b1;
            clr_cnt_reg <= 9'd0;
            out_valid_reg <= 1'b0;
            out_data_reg <= 8'd0;
            dma_src_reg <= 8'd0;
            dma_cnt_reg <= 8'd0;
        end else begin
            if (boot_load) boot_mapped_reg <= boot_value;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 9'd1;
                    if (clr_cnt_reg == 9'd511)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (take) begin
                        if (q_item.func == hmmbc_pkg::FUNC_READ) begin
                            state_reg <= ST_READ;
                        end else begin
                            out_data_reg <= 8'd0;
                            state_reg <= ST_DONE;
                        end
                        if (wr_en) begin
                            if (q_item.addr[15:13] == 3'b001) begin
                                if (controller_type == hmmbc_pkg::CTRL_MBC1)
                                    rom_bank_reg <= {2'b0, q_item.data[4:0]};
                                else if (controller_type == hmmbc_pkg::CTRL_MBC3)
                                    rom_bank_reg <= q_item.data[6:0];
                            end else if (q_item.addr[15:13] == 3'b010) begin
                                if (controller_type == hmmbc_pkg::CTRL_MBC1 ||
                                    (controller_type == hmmbc_pkg::CTRL_MBC3 &&
                                     q_item.data < 8'd4))
                                    ram_bank_reg <= q_item.data[1:0];
                            end else if (q_item.addr[15:13] == 3'b011) begin
                                if (controller_type == hmmbc_pkg::CTRL_MBC1)
                                    mode_reg <= q_item.data[0];
                            end
                            if (q_item.addr == hmmbc_pkg::ADDR_UNMAP && q_item.data == 8'd1)
                                boot_mapped_reg <= 1'b0;
                            if (q_item.addr == hmmbc_pkg::ADDR_DMA) begin
                                dma_src_reg <= q_item.data;
                                dma_cnt_reg <= 8'd0;
                                state_reg <= ST_DMA_RD;
                            end
                        end
                    end
                end
                ST_READ: begin
                    out_data_reg <= rd_byte;
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_DONE: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_DMA_RD: state_reg <= ST_DMA_WR;
                ST_DMA_WR: begin
                    if (dma_cnt_reg == hmmbc_pkg::OAM_COPY_BYTES - 8'd1) begin
                        state_reg <= ST_DONE;
                    end else begin
                        dma_cnt_reg <= dma_cnt_reg + 8'd1;
                        state_reg <= ST_DMA_RD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> !out_valid_reg)
        else $error("result raised in the cycle after take");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> out_valid_reg)
        else $error("read gave no result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DMA_RD) |-> dma_cnt_reg < hmmbc_pkg::OAM_COPY_BYTES)
        else $error("copy counter overran");
endmodule

/* rtl/core/handheld_memory_map_bank_controller.sv */
// Top level of the handheld memory map and bank controller.
// Usage: the slave stream carries one beat per item: CPU bus read, bus write,
// ROM load byte or boot load byte. Every item yields exactly one beat on the
// master stream; reads carry the mapped byte, all other items carry zero.
// Items enter a two-entry queue in the front end, so the sender can keep
// going while the back end works. The back end takes one item at a time.
// A read, write or load waits in the queue until the back end takes it; its
// result is registered after the registered memory read or update, and the
// back end takes no new item until the last result has been accepted.
// A write to the DMA register runs the 160-byte copy into the sprite area,
// one byte at a time through the single memory read port, each byte a read
// state then a write state; its result comes once the last byte is written.
// When the receiver stalls, the result register holds and the back end stops
// taking items; the queue then fills and the slave tready drops.
// Reset clears the queue, result and bank registers (ROM bank one), maps the
// boot ROM again and starts a pass that zeroes all 512 bytes of the high area;
// the queue takes up to two beats meanwhile. ROM, boot, video, cartridge and
// work RAM keep their contents over reset.
// Configuration writes are taken any cycle through cfg_wr_en; they are
// meant only while the block is idle.
module handheld_memory_map_bank_controller #(
    parameter int ROM_BANKS      = 32,
    parameter int CART_RAM_BANKS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // func[1:0], addr[17:2], load_index[36:18], data[44:37]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // read_data[7:0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);
    logic [1:0] ctrl_type_reg, ext_ram_reg;
    hmmbc_pkg::item_t in_item, q_item;
    logic q_valid, q_ready, boot_load;

    assign in_item.func       = hmmbc_pkg::func_t'(s_tdata[1:0]);
    assign in_item.addr       = s_tdata[17:2];
    assign in_item.load_index = s_tdata[36:18];
    assign in_item.data       = s_tdata[44:37];
    assign boot_load = cfg_wr_en && cfg_index == hmmbc_pkg::CFG_BOOT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_type_reg <= 2'd0;
            ext_ram_reg   <= 2'd0;
        end else if (cfg_wr_en) begin
            if (cfg_index == hmmbc_pkg::CFG_CTRL_TYPE) ctrl_type_reg <= cfg_data;
            if (cfg_index == hmmbc_pkg::CFG_EXT_RAM) ext_ram_reg <= cfg_data;
        end
    end

    hmmbc_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .q_valid, .q_ready, .q_item
    );

    hmmbc_back #(.ROM_BANKS(ROM_BANKS), .CART_RAM_BANKS(CART_RAM_BANKS)) u_back (
        .aclk, .aresetn,
        .controller_type(ctrl_type_reg), .ext_ram_code(ext_ram_reg),
        .boot_load, .boot_value(cfg_data[0]),
        .q_valid, .q_ready, .q_item,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
endmodule
